FILE: src/trfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfp_pkg
// Shared types and constants for the touch report frame parser.
// ----------------------------------------------------------------------------
package trfp_pkg;

  localparam int MAX_CONTACTS = 5;
  localparam int RECORD_BYTES = 8;
  localparam int STORE_BYTES  = 7;
  localparam int CNT_W        = 4;
  localparam int IDX_W        = 3;
  localparam int READY_BIT    = 7;

  typedef enum logic [1:0] {
    EV_CONTACT   = 2'd0,
    EV_IDLE      = 2'd1,
    EV_NOT_READY = 2'd2,
    EV_BAD_COUNT = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  contact_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] touch_width;
    logic        released;
    logic        frame_last;
  } result_t;

endpackage

FILE: src/touch_report_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_report_frame_parser
// Parses status bytes and contact records of a coordinate read stream.
// ----------------------------------------------------------------------------
// path: the input register holds an accepted byte, then the result register loads its result and raises out_valid
// throughput: one byte per cycle while the input is not stalled, set by the parser state update
// the input stalls only while a result waits in the result register
// reset: synchronous, clears frame state, previous count, swap_xy and valids
// record byte storage is not reset
module touch_report_frame_parser import trfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_kind,
  output logic [3:0]  contact_id,
  output logic [15:0] pos_x,
  output logic [15:0] pos_y,
  output logic [15:0] touch_width,
  output logic        released,
  output logic        frame_last
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    item_take;
  logic    res_valid;
  result_t res;
  logic    space;
  result_t out_res;

  assign cfg_ready = 1'b1;
  assign in_item   = '{data_byte: data_byte, frame_start: frame_start};
  assign item_take = item_valid && (!res_valid || space);

  trfp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  trfp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_valid  (res_valid),
    .res        (res)
  );

  trfp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (item_take && res_valid),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign event_kind  = out_res.kind;
  assign contact_id  = out_res.contact_id;
  assign pos_x       = out_res.pos_x;
  assign pos_y       = out_res.pos_y;
  assign touch_width = out_res.touch_width;
  assign released    = out_res.released;
  assign frame_last  = out_res.frame_last;

endmodule

FILE: src/trfp_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfp_in_stage
// Input register: holds one item for the parser and drives the input stall.
// ----------------------------------------------------------------------------
module trfp_in_stage import trfp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  in_stall,
  output logic  item_valid,
  output item_t item,
  input  logic  item_take
);

  assign in_stall = item_valid && !item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
  end

endmodule

FILE: src/trfp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfp_parser
// Frame state, record capture and result decode for one byte per cycle while item_take is high.
// ----------------------------------------------------------------------------
module trfp_parser import trfp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_valid,
  input  logic    cfg_data,
  input  logic    item_valid,
  input  item_t   item,
  input  logic    item_take,
  output logic    res_valid,
  output result_t res
);

  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_CONTACTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RECORD_BYTES - 1);
  localparam logic [IDX_W-1:0] STORE_N  = IDX_W'(STORE_BYTES);

  logic             swap_xy;
  logic             in_frame;
  logic [CNT_W-1:0] contacts_expected;
  logic [CNT_W-1:0] contacts_done;
  logic [IDX_W-1:0] record_byte_index;
  logic [CNT_W-1:0] previous_count;
  logic [7:0]       record_bytes [STORE_BYTES];

  logic             in_frame_next;
  logic [CNT_W-1:0] contacts_expected_next;
  logic [CNT_W-1:0] contacts_done_next;
  logic [IDX_W-1:0] record_byte_index_next;
  logic [CNT_W-1:0] previous_count_next;
  logic [7:0]       record_bytes_next [STORE_BYTES];

  logic [CNT_W-1:0] count;
  logic [15:0]      rec_x;
  logic [15:0]      rec_y;

  assign count = item.data_byte[CNT_W-1:0];

  always_comb begin
    in_frame_next          = in_frame;
    contacts_expected_next = contacts_expected;
    contacts_done_next     = contacts_done;
    record_byte_index_next = record_byte_index;
    previous_count_next    = previous_count;
    record_bytes_next      = record_bytes;
    res_valid              = 1'b0;
    res                    = '0;
    res.kind               = EV_CONTACT;
    rec_x                  = '0;
    rec_y                  = '0;
    if (item_valid) begin
      if (item.frame_start) begin
        in_frame_next          = 1'b0;
        contacts_done_next     = '0;
        record_byte_index_next = '0;
        priority if (!item.data_byte[READY_BIT]) begin
          res_valid      = 1'b1;
          res.kind       = EV_NOT_READY;
          res.frame_last = 1'b1;
        end else if (count > MAX_CNT) begin
          res_valid      = 1'b1;
          res.kind       = EV_BAD_COUNT;
          res.frame_last = 1'b1;
        end else if (count == '0) begin
          res_valid           = 1'b1;
          res.kind            = EV_IDLE;
          res.released        = (previous_count != '0);
          res.frame_last      = 1'b1;
          previous_count_next = '0;
        end else begin
          previous_count_next    = count;
          contacts_expected_next = count;
          in_frame_next          = 1'b1;
        end
      end else if (in_frame) begin
        if (record_byte_index < STORE_N) begin
          record_bytes_next[record_byte_index] = item.data_byte;
        end
        if (record_byte_index < LAST_IDX) begin
          record_byte_index_next = record_byte_index + 1'b1;
        end else begin
          record_byte_index_next = '0;
          contacts_done_next     = contacts_done + 1'b1;
          rec_x                  = {record_bytes_next[2], record_bytes_next[1]};
          rec_y                  = {record_bytes_next[4], record_bytes_next[3]};
          res_valid              = 1'b1;
          res.kind               = EV_CONTACT;
          res.contact_id         = record_bytes_next[0][3:0];
          res.pos_x              = swap_xy ? rec_y : rec_x;
          res.pos_y              = swap_xy ? rec_x : rec_y;
          res.touch_width        = {record_bytes_next[6], record_bytes_next[5]};
          res.frame_last         = (contacts_done_next >= contacts_expected);
          if (res.frame_last) begin
            in_frame_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_xy <= 1'b0;
    end else if (cfg_valid) begin
      swap_xy <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame          <= 1'b0;
      contacts_expected <= '0;
      contacts_done     <= '0;
      record_byte_index <= '0;
      previous_count    <= '0;
    end else if (item_take) begin
      in_frame          <= in_frame_next;
      contacts_expected <= contacts_expected_next;
      contacts_done     <= contacts_done_next;
      record_byte_index <= record_byte_index_next;
      previous_count    <= previous_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      record_bytes <= record_bytes_next;
    end
  end

endmodule

FILE: src/trfp_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfp_out_stage
// Result register toward the output channel.
// ----------------------------------------------------------------------------
module trfp_out_stage import trfp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    space,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  assign space = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && space) begin
      out_res <= res;
    end
  end

endmodule

FILE: src/trfp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfp_checker
// Port-level checks on the result channel of the frame parser.
// ----------------------------------------------------------------------------
module trfp_checker import trfp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  event_kind,
  input logic [3:0]  contact_id,
  input logic [15:0] pos_x,
  input logic [15:0] pos_y,
  input logic [15:0] touch_width,
  input logic        released,
  input logic        frame_last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(pos_x)
      && $stable(pos_y) && $stable(frame_last))
    else $error("stalled item changed");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != EV_CONTACT |-> frame_last)
    else $error("status item without frame_last");

  a_status_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != EV_CONTACT |->
      contact_id == '0 && pos_x == '0 && pos_y == '0 && touch_width == '0)
    else $error("status item carries contact fields");

  a_release_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && released |-> event_kind == EV_IDLE)
    else $error("release outside idle item");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind touch_report_frame_parser trfp_checker u_trfp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .event_kind  (event_kind),
  .contact_id  (contact_id),
  .pos_x       (pos_x),
  .pos_y       (pos_y),
  .touch_width (touch_width),
  .released    (released),
  .frame_last  (frame_last)
);
